// ===== design/imq_pkg.sv =====
// Package for the I/O request merge queue: shared types, codes and defaults.
// No dependencies; imported by every module of the block except imq_ram.
package imq_pkg;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_ADDR_BITS   = 32;

  localparam logic [31:0] LEN_MAX = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    ST_QUEUED     = 3'd0,
    ST_MERGED     = 3'd1,
    ST_DROPPED    = 3'd2,
    ST_DISPATCHED = 3'd3,
    ST_NONE       = 3'd4
  } status_t;

  // Item class worked out by the front end
  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_POLL = 2'd1,
    OP_HOLD = 2'd2
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] start;
    logic [15:0] count;
    logic        wr;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_MERGE,
    S_ALLOC,
    S_FREE,
    S_INSERT,
    S_LINK,
    S_POP
  } state_t;

endpackage

// ===== design/io_request_merge_queue.sv =====
// Sorted block-request queue with merging of touching same-direction ranges.
// An add walks the list from the head, one entry per clock through the entry RAM's
// registered read port. An add that inserts goes through S_ALLOC, then S_FREE when
// its slot comes off the free list, then S_INSERT, then S_LINK when it is linked
// behind another entry. A merge ends in S_MERGE and a drop in the walk. A dispatching
// poll goes through S_POP, and a busy or empty poll is answered from S_IDLE. The back
// end starts a new item only after the previous result has been taken.
// A two-item input queue and an output register let both sides stall on their own.
// No clearing pass after reset: slots come from a fill counter, then a free list.
module io_request_merge_queue import imq_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int ADDR_BITS   = DEF_ADDR_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [31:0] start_block,
  input  logic [15:0] block_count,
  input  logic        is_write,
  input  logic        device_busy,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] out_start,
  output logic [31:0] out_count,
  output logic        out_is_write
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  imq_front #(.ADDR_BITS(ADDR_BITS)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .start_block(start_block), .block_count(block_count),
    .is_write(is_write), .device_busy(device_busy),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
  );

  imq_engine #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_engine (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_in(cmd),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .out_start(out_start), .out_count(out_count),
    .out_is_write(out_is_write)
  );

endmodule

// ===== design/imq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module imq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/imq_front.sv =====
// Front end: accepts items, classifies them and holds them in a two-entry queue.
// Depends on imq_pkg.
module imq_front import imq_pkg::*; #(
  parameter int ADDR_BITS = DEF_ADDR_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [31:0] start_block,
  input  logic [15:0] block_count,
  input  logic        is_write,
  input  logic        device_busy,
  output logic        cmd_valid,
  input  logic        cmd_ready,
  output cmd_t        cmd
);

  localparam logic [63:0] ADDR_MASK = (64'd1 << ADDR_BITS) - 64'd1;

  cmd_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       cmd_in;
  logic       push;
  logic       pop;

  // Classify the incoming item
  always_comb begin
    cmd_in.op    = func ? (device_busy ? OP_HOLD : OP_POLL) : OP_ADD;
    cmd_in.start = start_block & ADDR_MASK[31:0];
    cmd_in.count = block_count;
    cmd_in.wr    = is_write;
  end

  assign in_ready  = (count != 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = slot[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  // Store payload
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= cmd_in;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== design/imq_engine.sv =====
// Back end: keeps the sorted request list as a linked list in two RAMs,
// walks it one entry a cycle, merges, inserts and pops. Depends on imq_pkg, imq_ram.
module imq_engine import imq_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cmd_t        cmd_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] out_start,
  output logic [31:0] out_count,
  output logic        out_is_write
);

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);
  localparam int DW = 65;

  state_t        state, state_next;
  cmd_t          cmd, cmd_next;
  logic [IW-1:0] head, head_next;
  logic [IW-1:0] free_head, free_head_next;
  logic [CW-1:0] fresh, fresh_next;
  logic [CW-1:0] occ, occ_next;
  logic [IW-1:0] cur, cur_next;
  logic [IW-1:0] prev, prev_next;
  logic          prev_valid, prev_valid_next;
  logic [CW-1:0] idx, idx_next;
  logic [IW-1:0] new_idx, new_idx_next;
  logic [31:0]   es_q, es_next;
  logic [32:0]   ee_q, ee_next;

  // RAM ports
  logic          d_we, n_we;
  logic [IW-1:0] d_waddr, n_waddr, d_raddr, n_raddr;
  logic [DW-1:0] d_wdata, d_rdata;
  logic [IW-1:0] n_wdata, n_rdata;

  // Walk datapath
  logic [32:0] new_end;
  logic [31:0] rd_start, rd_len;
  logic        rd_wr;
  logic [32:0] rd_end;
  logic        hit, past;
  logic [31:0] ms;
  logic [32:0] me, ml;

  // Result load
  logic          res_load;
  status_t       res_status;
  logic [31:0]   res_start, res_count;
  logic          res_wr;

  imq_ram #(.WIDTH(DW), .DEPTH(QUEUE_DEPTH)) u_data (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .raddr(d_raddr), .rdata(d_rdata)
  );

  imq_ram #(.WIDTH(IW), .DEPTH(QUEUE_DEPTH)) u_link (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .raddr(n_raddr), .rdata(n_rdata)
  );

  assign new_end  = {1'b0, cmd.start} + {17'd0, cmd.count};
  assign rd_start = d_rdata[31:0];
  assign rd_len   = d_rdata[63:32];
  assign rd_wr    = d_rdata[64];
  assign rd_end   = {1'b0, rd_start} + {1'b0, rd_len};
  assign hit      = (rd_wr == cmd.wr) && (new_end >= {1'b0, rd_start})
                    && ({1'b0, cmd.start} <= rd_end);
  assign past     = (rd_start > cmd.start);
  assign ms       = (cmd.start < es_q) ? cmd.start : es_q;
  assign me       = (new_end > ee_q) ? new_end : ee_q;
  assign ml       = me - {1'b0, ms};

  // Next state and datapath control
  always_comb begin
    state_next      = state;
    cmd_next        = cmd;
    head_next       = head;
    free_head_next  = free_head;
    fresh_next      = fresh;
    occ_next        = occ;
    cur_next        = cur;
    prev_next       = prev;
    prev_valid_next = prev_valid;
    idx_next        = idx;
    new_idx_next    = new_idx;
    es_next         = es_q;
    ee_next         = ee_q;
    cmd_ready       = 1'b0;
    d_we            = 1'b0;
    d_waddr         = cur;
    d_wdata         = {cmd.wr, 16'd0, cmd.count, cmd.start};
    d_raddr         = head;
    n_we            = 1'b0;
    n_waddr         = new_idx;
    n_wdata         = cur;
    n_raddr         = n_rdata;
    res_load        = 1'b0;
    res_status      = ST_NONE;
    res_start       = 32'd0;
    res_count       = 32'd0;
    res_wr          = 1'b0;
    case (state)
      S_IDLE: begin
        n_raddr = head;
        if (cmd_valid && !out_valid) begin
          cmd_ready       = 1'b1;
          cmd_next        = cmd_in;
          cur_next        = head;
          prev_valid_next = 1'b0;
          idx_next        = '0;
          case (cmd_in.op)
            OP_ADD: begin
              if (occ != '0) begin
                state_next = S_WALK;
              end else begin
                state_next = S_ALLOC;
              end
            end
            OP_POLL: begin
              if (occ != '0) begin
                state_next = S_POP;
              end else begin
                res_load = 1'b1;
              end
            end
            default: res_load = 1'b1;
          endcase
        end
      end
      S_WALK: begin
        n_raddr = n_rdata;
        d_raddr = n_rdata;
        es_next = rd_start;
        ee_next = rd_end;
        if (hit) begin
          state_next = S_MERGE;
        end else if (past) begin
          // Insert before the current entry, or drop if the queue is full
          if (occ == FULL) begin
            res_load   = 1'b1;
            res_status = ST_DROPPED;
            state_next = S_IDLE;
          end else begin
            state_next = S_ALLOC;
          end
        end else begin
          prev_next       = cur;
          prev_valid_next = 1'b1;
          if (idx == occ - CW'(1)) begin
            // Append at the tail, or drop if the queue is full
            if (occ == FULL) begin
              res_load   = 1'b1;
              res_status = ST_DROPPED;
              state_next = S_IDLE;
            end else begin
              state_next = S_ALLOC;
            end
          end else begin
            cur_next = n_rdata;
            idx_next = idx + CW'(1);
          end
        end
      end
      S_MERGE: begin
        d_we       = 1'b1;
        d_waddr    = cur;
        d_wdata    = {cmd.wr, (ml[32] ? LEN_MAX : ml[31:0]), ms};
        res_load   = 1'b1;
        res_status = ST_MERGED;
        state_next = S_IDLE;
      end
      S_ALLOC: begin
        n_raddr = free_head;
        if (fresh != FULL) begin
          new_idx_next = fresh[IW-1:0];
          fresh_next   = fresh + CW'(1);
          state_next   = S_INSERT;
        end else begin
          state_next = S_FREE;
        end
      end
      S_FREE: begin
        new_idx_next   = free_head;
        free_head_next = n_rdata;
        state_next     = S_INSERT;
      end
      S_INSERT: begin
        d_we    = 1'b1;
        d_waddr = new_idx;
        n_we    = 1'b1;
        n_waddr = new_idx;
        n_wdata = cur;
        if (prev_valid) begin
          state_next = S_LINK;
        end else begin
          head_next  = new_idx;
          occ_next   = occ + CW'(1);
          res_load   = 1'b1;
          res_status = ST_QUEUED;
          state_next = S_IDLE;
        end
      end
      S_LINK: begin
        n_we       = 1'b1;
        n_waddr    = prev;
        n_wdata    = new_idx;
        occ_next   = occ + CW'(1);
        res_load   = 1'b1;
        res_status = ST_QUEUED;
        state_next = S_IDLE;
      end
      S_POP: begin
        // Return the head and push its slot onto the free list
        n_we           = 1'b1;
        n_waddr        = head;
        n_wdata        = free_head;
        free_head_next = head;
        head_next      = n_rdata;
        occ_next       = occ - CW'(1);
        res_load       = 1'b1;
        res_status     = ST_DISPATCHED;
        res_start      = rd_start;
        res_count      = rd_len;
        res_wr         = rd_wr;
        state_next     = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      free_head <= '0;
      fresh     <= '0;
      occ       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      free_head <= free_head_next;
      fresh     <= fresh_next;
      occ       <= occ_next;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers and result payload
  always_ff @(posedge clk) begin
    cmd        <= cmd_next;
    cur        <= cur_next;
    prev       <= prev_next;
    prev_valid <= prev_valid_next;
    idx        <= idx_next;
    new_idx    <= new_idx_next;
    es_q       <= es_next;
    ee_q       <= ee_next;
    if (res_load) begin
      status       <= res_status;
      out_start    <= res_start;
      out_count    <= res_count;
      out_is_write <= res_wr;
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst) occ <= FULL)
    else $error("occupancy above queue depth");

  a_fresh_bound: assert property (@(posedge clk) disable iff (rst) fresh >= occ)
    else $error("more entries live than slots ever allocated");

  a_occ_step: assert property (@(posedge clk) disable iff (rst)
    (occ == $past(occ)) || (occ == $past(occ) + CW'(1)) || (occ == $past(occ) - CW'(1)))
    else $error("occupancy moved by more than one");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    res_load && (res_status == ST_DROPPED) |-> occ == FULL)
    else $error("request dropped with room left");

endmodule
